/* rtl/assert_macros.svh */
// Assertion macros shared by the regulator RTL.
// Expects aclk, and for BSLR_ASSERT also aresetn, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define BSLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define BSLR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/bslr_pkg.sv */
// Shared types, constants and step tables of the banded-step load regulator.
// No dependencies.
`default_nettype none

package bslr_pkg;

    localparam int IN_W      = 40;
    localparam int OUT_W     = 96;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam int DVD_W     = 32;
    localparam int DVS_W     = 24;
    localparam int ITER_W    = 6;
    localparam int BAND_N    = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CGAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VGAIN   = 2'd3;

    localparam logic [1:0] MODE_RES = 2'd0;
    localparam logic [1:0] MODE_CUR = 2'd1;
    localparam logic [1:0] MODE_PWR = 2'd2;

    localparam logic [1:0] ENC_UP = 2'b01;

    localparam logic [23:0] SP_MAX          = 24'hFFFFFF;
    localparam logic [16:0] ZERO_OHM_TARGET = 17'h1FFFF;
    localparam logic [17:0] CGAIN_RST       = 18'd11973;
    localparam logic [17:0] VGAIN_RST       = 18'd135299;

    localparam logic [36:0] Q16_HALF  = 37'd32768;
    localparam logic [31:0] PWR_HALF  = 32'd500;
    // Reciprocal of 1000 scaled by 2^38, exact for any 32-bit numerator.
    localparam logic [28:0] PWR_RECIP = 29'd274877907;

    localparam logic [ITER_W-1:0] RES_ITERS = 6'd17;

    typedef struct packed {
        logic               start;
        logic [ITER_W-1:0]  iters;
    } div_ctl_t;

    // Band threshold in tenths of the target, widest band first.
    function automatic logic [3:0] band_frac(input logic [2:0] idx);
        logic [3:0] k;
        case (idx)
            3'd0:    k = 4'd8;
            3'd1:    k = 4'd6;
            3'd2:    k = 4'd4;
            3'd3:    k = 4'd3;
            3'd4:    k = 4'd2;
            default: k = 4'd1;
        endcase
        return k;
    endfunction

    function automatic logic [8:0] band_step(input logic [2:0] idx);
        logic [8:0] s;
        case (idx)
            3'd0:    s = 9'd300;
            3'd1:    s = 9'd170;
            3'd2:    s = 9'd120;
            3'd3:    s = 9'd60;
            3'd4:    s = 9'd40;
            default: s = 9'd30;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/banded_step_load_regulator.sv */
// Top level of the banded-step load regulator: sequencer, state and stream ports.
// Depends on bslr_pkg, bslr_mul, bslr_div and assert_macros.svh.
//
// Each input transaction carries one current and one voltage sample and returns one
// result transaction with the new drive code, the measured mA, mV and mW and the
// setpoint in use. The shared multiplier scales current, voltage and power in turn, and
// the power is rounded to mW by a reciprocal multiplication. In resistance mode with a
// nonzero setpoint the 17-step serial divider then forms the resistance target; current
// and power mode, the undefined mode and a zero resistance setpoint skip it. Up to six
// band compares follow. s_tready is high only between transactions, and a new
// transaction is taken while the previous result still waits on the master side.
// Configuration writes are taken on any cycle and must be made while idle; a write of
// the initial setpoint reloads the active setpoint.
`default_nettype none

`include "assert_macros.svh"

module banded_step_load_regulator #(
    parameter int DRIVE_MAX = 4095
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // current_raw[15:0], voltage_raw[31:16], encoder_step[33:32], pause[34]
    input  wire logic [bslr_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // dac_drive[11:0], current_ma[27:12], voltage_mv[44:28], power_mw[68:45],
    // setpoint_now[92:69]
    output logic [bslr_pkg::OUT_W-1:0]           m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bslr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bslr_pkg::CFG_W-1:0]      cfg_data
);

    import bslr_pkg::*;

    localparam int DW  = $clog2(DRIVE_MAX + 1);
    localparam int DSW = ((DW > 9) ? DW : 9) + 2;
    localparam logic signed [DSW-1:0] DRV_MAX_S = DSW'(DRIVE_MAX);
    localparam logic [DW-1:0]         DRV_MAX_U = DW'(DRIVE_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_C, S_RND_C, S_RND_V, S_MUL_P, S_PWR, S_PWR_W, S_PWR_Q,
        S_RES_W, S_ERR, S_BAND, S_UPD, S_OUT
    } state_t;

    state_t state_reg;

    logic [1:0]  mode_reg;
    logic [17:0] cgain_reg;
    logic [17:0] vgain_reg;
    logic [23:0] sp_reg;
    logic [DW-1:0] drive_level_reg;

    logic signed [15:0] craw_reg;
    logic [14:0]        vraw_reg;
    logic               pause_reg;
    logic signed [15:0] cur_reg;
    logic [16:0]        volt_reg;
    logic signed [23:0] pwr_reg;
    logic               pneg_reg;
    logic [31:0]        pnum_reg;
    logic [22:0]        pq_reg;
    logic [23:0]        target_reg;
    logic [28:0]        ten_err_reg;
    logic               up_reg;
    logic               dn_reg;
    logic [2:0]         band_idx_reg;
    logic [8:0]         step_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               m_tvalid_reg;

    // Input fields.
    logic signed [15:0] in_craw;
    logic [15:0]        in_vraw;
    logic [1:0]         in_enc;

    assign in_craw = s_tdata[15:0];
    assign in_vraw = s_tdata[31:16];
    assign in_enc  = s_tdata[33:32];

    // Shared multiplier.
    logic signed [17:0] mul_a;
    logic        [17:0] mul_b;
    logic signed [36:0] mul_prod;

    always_comb begin
        case (state_reg)
            S_MUL_C: begin
                mul_a = 18'(craw_reg);
                mul_b = cgain_reg;
            end
            S_RND_C: begin
                mul_a = {3'b0, vraw_reg};
                mul_b = vgain_reg;
            end
            default: begin
                mul_a = 18'(cur_reg);
                mul_b = {1'b0, volt_reg};
            end
        endcase
    end

    bslr_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (mul_prod)
    );

    // Rounding of the product, halves away from zero.
    logic        prod_neg;
    logic [36:0] prod_mag;
    logic [36:0] prod_rnd;
    logic [20:0] q16;
    logic signed [15:0] cur_sat;
    logic [16:0]        volt_sat;

    assign prod_neg = mul_prod[36];
    assign prod_mag = prod_neg ? 37'(-mul_prod) : 37'(mul_prod);
    assign prod_rnd = prod_mag + Q16_HALF;
    assign q16      = prod_rnd[36:16];

    always_comb begin
        if (!prod_neg) begin
            cur_sat = (q16 > 21'd32767) ? 16'sh7FFF : $signed(q16[15:0]);
        end else begin
            cur_sat = (q16 > 21'd32768) ? 16'sh8000 : $signed(~q16[15:0] + 16'd1);
        end
    end

    assign volt_sat = (q16 > 21'd131071) ? 17'h1FFFF : q16[16:0];

    // Power to mW by reciprocal multiplication.
    logic [60:0] pwr_prod;

    assign pwr_prod = 61'(pnum_reg) * 61'(PWR_RECIP);

    // Serial divider for the resistance target.
    div_ctl_t          div_ctl;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic              res_div;

    assign res_div = (mode_reg == MODE_RES) && (sp_reg != '0);

    always_comb begin
        div_ctl.start = (state_reg == S_PWR) && res_div;
        div_ctl.iters = RES_ITERS;
        div_dividend  = {volt_reg, 15'b0};
        div_divisor   = sp_reg;
    end

    bslr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Error against target.
    logic signed [23:0] meas;
    logic signed [25:0] diff;
    logic [24:0]        err;

    assign meas = (mode_reg == MODE_PWR) ? pwr_reg : 24'(cur_reg);
    assign diff = $signed({2'b0, target_reg}) - 26'(meas);
    assign err  = diff[25] ? 25'(-diff) : diff[24:0];

    logic [27:0] kt;
    assign kt = 28'(target_reg) * 28'(band_frac(band_idx_reg));

    // Drive update.
    logic signed [DSW-1:0] drv_base;
    logic signed [DSW-1:0] drv_step;
    logic signed [DSW-1:0] drv_sum;
    logic [DW-1:0]         drv_sat;

    assign drv_base = $signed({{(DSW-DW){1'b0}}, drive_level_reg});
    assign drv_step = $signed({{(DSW-9){1'b0}}, step_reg});

    always_comb begin
        if (up_reg) begin
            drv_sum = drv_base + drv_step;
        end else if (dn_reg) begin
            drv_sum = drv_base - drv_step;
        end else begin
            drv_sum = drv_base;
        end
        if (drv_sum < 0) begin
            drv_sat = '0;
        end else if (drv_sum > DRV_MAX_S) begin
            drv_sat = DRV_MAX_U;
        end else begin
            drv_sat = drv_sum[DW-1:0];
        end
    end

    logic [DW+11:0] drive_ext;
    logic [11:0]    dac_val;
    logic           out_free;

    assign drive_ext = {12'b0, drive_level_reg};
    assign dac_val   = pause_reg ? 12'd0 : drive_ext[11:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_reg        <= MODE_CUR;
            cgain_reg       <= CGAIN_RST;
            vgain_reg       <= VGAIN_RST;
            sp_reg          <= '0;
            drive_level_reg <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            craw_reg        <= '0;
            vraw_reg        <= '0;
            pause_reg       <= 1'b0;
            cur_reg         <= '0;
            volt_reg        <= '0;
            pwr_reg         <= '0;
            pneg_reg        <= 1'b0;
            pnum_reg        <= '0;
            pq_reg          <= '0;
            target_reg      <= '0;
            ten_err_reg     <= '0;
            up_reg          <= 1'b0;
            dn_reg          <= 1'b0;
            band_idx_reg    <= '0;
            step_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MODE:    mode_reg  <= cfg_data[1:0];
                    REG_INIT_SP: sp_reg    <= cfg_data;
                    REG_CGAIN:   cgain_reg <= cfg_data[17:0];
                    REG_VGAIN:   vgain_reg <= cfg_data[17:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        craw_reg  <= in_craw;
                        vraw_reg  <= in_vraw[15] ? 15'd0 : in_vraw[14:0];
                        pause_reg <= s_tdata[34];
                        if (in_enc == ENC_UP) begin
                            if (sp_reg != SP_MAX) begin
                                sp_reg <= sp_reg + 24'd1;
                            end
                        end else if (in_enc[1]) begin
                            if (sp_reg != '0) begin
                                sp_reg <= sp_reg - 24'd1;
                            end
                        end
                        state_reg <= S_MUL_C;
                    end
                end
                S_MUL_C: state_reg <= S_RND_C;
                S_RND_C: begin
                    cur_reg   <= cur_sat;
                    state_reg <= S_RND_V;
                end
                S_RND_V: begin
                    volt_reg  <= volt_sat;
                    state_reg <= S_MUL_P;
                end
                S_MUL_P: state_reg <= S_PWR;
                S_PWR: begin
                    pneg_reg  <= prod_neg;
                    pnum_reg  <= prod_mag[31:0] + PWR_HALF;
                    state_reg <= S_PWR_W;
                end
                S_PWR_W: begin
                    pq_reg    <= pwr_prod[60:38];
                    state_reg <= S_PWR_Q;
                end
                S_PWR_Q: begin
                    pwr_reg <= pneg_reg ? $signed(-{1'b0, pq_reg}) : $signed({1'b0, pq_reg});
                    if (res_div) begin
                        state_reg <= S_RES_W;
                    end else begin
                        target_reg <= (mode_reg == MODE_RES) ? 24'(ZERO_OHM_TARGET)
                                                             : sp_reg;
                        state_reg  <= S_ERR;
                    end
                end
                S_RES_W: begin
                    if (div_done) begin
                        target_reg <= 24'(div_q[16:0]);
                        state_reg  <= S_ERR;
                    end
                end
                S_ERR: begin
                    ten_err_reg  <= {1'b0, err, 3'b0} + {3'b0, err, 1'b0};
                    up_reg       <= !diff[25] && (diff != '0);
                    dn_reg       <= diff[25];
                    band_idx_reg <= '0;
                    state_reg    <= S_BAND;
                end
                S_BAND: begin
                    if (ten_err_reg > {1'b0, kt}) begin
                        step_reg  <= band_step(band_idx_reg);
                        state_reg <= S_UPD;
                    end else if (band_idx_reg == 3'(BAND_N - 1)) begin
                        step_reg  <= 9'd1;
                        state_reg <= S_UPD;
                    end else begin
                        band_idx_reg <= band_idx_reg + 3'd1;
                    end
                end
                S_UPD: begin
                    if (mode_reg == MODE_RES || mode_reg == MODE_CUR ||
                        mode_reg == MODE_PWR) begin
                        drive_level_reg <= drv_sat;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {3'b0, sp_reg, pwr_reg, volt_reg, cur_reg, dac_val};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BSLR_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `BSLR_ASSERT(a_out_from_seq, $rose(m_tvalid) |-> $past(state_reg == S_OUT), "stray result")
    `BSLR_ASSERT(a_pause_zero, (state_reg == S_OUT && out_free && pause_reg) |=> (m_tdata[11:0] == 12'd0), "paused drive not zero")
    `BSLR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire

/* rtl/bslr_mul.sv */
// Shared registered multiplier: signed operand times unsigned gain.
// Depends on nothing but the clock.
`default_nettype none

module bslr_mul (
    input  wire logic               aclk,
    input  wire logic signed [17:0] mul_a,
    input  wire logic        [17:0] mul_b,
    output logic signed      [36:0] prod
);

    logic signed [36:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 37'(mul_a * $signed({1'b0, mul_b}));
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/bslr_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Uses bslr_pkg for widths and the control struct.
`default_nettype none

module bslr_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bslr_pkg::div_ctl_t          ctl,
    input  wire logic [bslr_pkg::DVD_W-1:0]  dividend,
    input  wire logic [bslr_pkg::DVS_W-1:0]  divisor,
    output logic                             done,
    output logic [bslr_pkg::DVD_W-1:0]       quotient
);

    import bslr_pkg::*;

    logic [ITER_W-1:0] cnt_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic              done_reg;
    logic [DVS_W+1:0]  trial;
    logic              borrow;

    assign trial  = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b0, dvs_reg};
    assign borrow = trial[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            dvd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                cnt_reg <= ctl.iters;
                rem_reg <= '0;
                dvs_reg <= divisor;
                dvd_reg <= dividend;
            end else if (cnt_reg != '0) begin
                rem_reg <= borrow ? {rem_reg[DVS_W-2:0], dvd_reg[DVD_W-1]}
                                  : trial[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], ~borrow};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

/* tb/sv/banded_step_load_regulator_test.sv */
// Self-checking testbench for the banded-step load regulator: directed corners, then
// randomized regulation runs over many register settings with random idling on both sides.
// Depends on bslr_pkg and banded_step_load_regulator.
`default_nettype none

module banded_step_load_regulator_test;

    import bslr_pkg::*;

    localparam int DRIVE_LIMIT = 4095;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [1:0] ENC_NONE      = 2'b00;
    localparam logic [1:0] ENC_DOWN      = 2'b11;
    localparam logic [1:0] ENC_DOWN_WIDE = 2'b10;

    typedef struct packed {
        logic              pause;
        logic [1:0]        encoder_step;
        logic signed [15:0] voltage_raw;
        logic signed [15:0] current_raw;
    } load_sample_t;

    typedef struct packed {
        logic [23:0]        setpoint_now;
        logic signed [23:0] power_mw;
        logic [16:0]        voltage_mv;
        logic signed [15:0] current_ma;
        logic [11:0]        dac_drive;
    } reading_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // regulator shadow state
    logic [1:0]  sel_mode;
    logic [23:0] active_sp;
    logic [17:0] cgain;
    logic [17:0] vgain;
    longint      drive_level;

    reading_t expected_readings[$];
    int idle_max = 5;
    int out_hold = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int regs_written = 0;

    banded_step_load_regulator #(
        .DRIVE_MAX(DRIVE_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_away(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint scale_q16(input longint raw, input logic [17:0] gain,
                                         input longint lo, input longint hi);
        return clamp(round_away(raw * longint'(gain), 65536), lo, hi);
    endfunction

    function automatic longint track_goal(input longint volt);
        if (sel_mode == MODE_RES) begin
            return (active_sp == 0) ? longint'(ZERO_OHM_TARGET) : volt / longint'(active_sp);
        end
        return longint'(active_sp);
    endfunction

    function automatic reading_t regulate(input load_sample_t smp);
        longint craw, vraw, cur, volt, pwr, goal, meas, err, step;
        reading_t r;
        craw = longint'(smp.current_raw);
        vraw = longint'(smp.voltage_raw);
        if (vraw < 0) vraw = 0;
        if (smp.encoder_step == ENC_UP) begin
            if (active_sp != SP_MAX) active_sp = active_sp + 1'b1;
        end else if (smp.encoder_step[1]) begin
            if (active_sp != 0) active_sp = active_sp - 1'b1;
        end
        cur = scale_q16(craw, cgain, -32768, 32767);
        volt = scale_q16(vraw, vgain, 0, 131071);
        pwr = clamp(round_away(cur * volt, 1000), -8388608, 8388607);
        if (sel_mode != MODE_UNUSED) begin
            goal = track_goal(volt);
            meas = (sel_mode == MODE_PWR) ? pwr : cur;
            err = (goal > meas) ? goal - meas : meas - goal;
            if (10 * err > 8 * goal) step = 300;
            else if (10 * err > 6 * goal) step = 170;
            else if (10 * err > 4 * goal) step = 120;
            else if (10 * err > 3 * goal) step = 60;
            else if (10 * err > 2 * goal) step = 40;
            else if (10 * err > goal) step = 30;
            else step = 1;
            if (goal > meas) drive_level = drive_level + step;
            else if (goal < meas) drive_level = drive_level - step;
            drive_level = clamp(drive_level, 0, DRIVE_LIMIT);
        end
        r.dac_drive = smp.pause ? 12'd0 : 12'(drive_level);
        r.current_ma = 16'(cur);
        r.voltage_mv = 17'(volt);
        r.power_mw = 24'(pwr);
        r.setpoint_now = active_sp;
        return r;
    endfunction

    function automatic logic [15:0] count_for(input longint ma);
        longint v;
        if (cgain == 0) return 16'($urandom);
        v = ma * 65536 / longint'(cgain);
        return 16'(clamp(v, -32768, 32767));
    endfunction

    function automatic logic [15:0] corner_count();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic load_sample_t pack_sample(input logic [15:0] craw,
                                                 input logic [15:0] vraw,
                                                 input logic [1:0] enc, input logic pause);
        load_sample_t smp;
        smp.current_raw = craw;
        smp.voltage_raw = vraw;
        smp.encoder_step = enc;
        smp.pause = pause;
        return smp;
    endfunction

    // mostly samples near the regulation target, the rest noise and rail values
    function automatic load_sample_t make_sample();
        load_sample_t smp;
        longint volt, want;
        int kind, pick, frac, jitter;
        kind = $urandom_range(0, 9);
        pick = $urandom_range(0, 9);
        frac = $urandom_range(0, 20);
        jitter = $urandom_range(0, 4);
        smp.pause = ($urandom_range(0, 4) == 0);
        smp.encoder_step = (pick == 0) ? ENC_UP : (pick == 1) ? ENC_DOWN :
                           (pick == 2) ? ENC_DOWN_WIDE : ENC_NONE;
        if (kind <= 5) begin
            smp.voltage_raw = 16'($urandom_range(0, 32767));
            volt = scale_q16(longint'(smp.voltage_raw), vgain, 0, 131071);
            want = track_goal(volt) * frac / 10 + jitter - 2;
            if (sel_mode == MODE_PWR && volt != 0) want = want * 1000 / volt;
            smp.current_raw = count_for(want);
        end else if (kind <= 8) begin
            smp.current_raw = 16'($urandom);
            smp.voltage_raw = 16'($urandom);
        end else begin
            smp.current_raw = corner_count();
            smp.voltage_raw = corner_count();
        end
        return smp;
    endfunction

    function automatic void check_field(input string field_name, input longint want,
                                        input longint seen);
        if (want != seen) begin
            $error("%s: expected %0d, actual %0d", field_name, want, seen);
            mismatches++;
        end
    endfunction

    task automatic send_sample(input load_sample_t smp);
        int gap;
        gap = $urandom_range(0, idle_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = IN_W'(smp);
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_readings.push_back(regulate(smp));
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_MODE:    sel_mode = value[1:0];
            REG_INIT_SP: active_sp = value;
            REG_CGAIN:   cgain = value[17:0];
            REG_VGAIN:   vgain = value[17:0];
            default: ;
        endcase
        regs_written++;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_sample(pack_sample(16'h0000, 16'h0000, ENC_NONE, 1'b0));
        send_sample(pack_sample(16'h7FFF, 16'h7FFF, ENC_NONE, 1'b0));
        send_sample(pack_sample(16'h8000, 16'h8000, ENC_UP, 1'b0));
        send_sample(pack_sample(16'h0001, 16'h0001, ENC_DOWN_WIDE, 1'b1));
        send_sample(pack_sample(16'hFFFF, 16'd100, ENC_DOWN, 1'b0));
        send_sample(pack_sample(16'd5, 16'd5, ENC_UP, 1'b1));
    endtask

    task automatic test_corner_settings();
        wait_idle();
        write_reg(REG_CGAIN, 24'd262143);
        write_reg(REG_VGAIN, 24'd262143);
        write_reg(REG_MODE, 24'(MODE_RES));
        write_reg(REG_INIT_SP, 24'd0);
        send_sample(pack_sample(16'h7FFF, 16'h7FFF, ENC_NONE, 1'b0));
        send_sample(pack_sample(16'h8000, 16'h7FFF, ENC_NONE, 1'b1));
        wait_idle();
        write_reg(REG_INIT_SP, 24'd7);
        send_sample(pack_sample(16'd1000, 16'd20000, ENC_UP, 1'b0));
        wait_idle();
        write_reg(REG_MODE, 24'(MODE_UNUSED));
        send_sample(pack_sample(16'hFFFB, 16'd300, ENC_DOWN, 1'b0));
        wait_idle();
        write_reg(REG_CGAIN, 24'd0);
        write_reg(REG_VGAIN, 24'd0);
        write_reg(REG_MODE, 24'(MODE_PWR));
        write_reg(REG_INIT_SP, SP_MAX);
        // push the drive into its upper rail and the setpoint into its top
        for (int i = 0; i < 15; i++) begin
            send_sample(pack_sample(16'($urandom), 16'($urandom),
                                    (i % 3 == 1) ? ENC_DOWN_WIDE : ENC_UP, (i % 4 == 0)));
        end
    endtask

    task automatic test_random_regulation();
        logic [1:0] mode_sel;
        logic [23:0] sp;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            idle_max = (p == 4) ? 0 : 5;
            case (p)
                0, 4:    mode_sel = MODE_CUR;
                1, 3:    mode_sel = MODE_RES;
                2, 5:    mode_sel = MODE_PWR;
                6:       mode_sel = MODE_UNUSED;
                default: mode_sel = 2'($urandom_range(0, 2));
            endcase
            case (mode_sel)
                MODE_RES: sp = (p == 3) ? 24'($urandom_range(0, 20))
                                        : 24'($urandom_range(1, 2000));
                MODE_PWR: sp = 24'($urandom_range(0, 5000000));
                default:  sp = 24'($urandom_range(0, 40000));
            endcase
            write_reg(REG_MODE, 24'(mode_sel));
            write_reg(REG_INIT_SP, sp);
            case (p % 4)
                0: begin
                    write_reg(REG_CGAIN, 24'(CGAIN_RST));
                    write_reg(REG_VGAIN, 24'(VGAIN_RST));
                end
                1: begin
                    write_reg(REG_CGAIN, 24'($urandom_range(0, 262143)));
                    write_reg(REG_VGAIN, 24'($urandom_range(0, 262143)));
                end
                2: begin
                    write_reg(REG_CGAIN, 24'd262143);
                    write_reg(REG_VGAIN, 24'($urandom_range(1, 262143)));
                end
                default: begin
                    write_reg(REG_CGAIN, 24'($urandom_range(1, 20000)));
                    write_reg(REG_VGAIN, 24'($urandom_range(1, 20000)));
                end
            endcase
            repeat (100) send_sample(make_sample());
        end
    endtask

    always @(negedge aclk) begin
        if (out_hold > 0) begin
            m_tready = 1'b0;
            out_hold--;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        reading_t exp_r;
        reading_t got_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("result transaction with no sample pending");
                mismatches++;
            end else begin
                exp_r = expected_readings.pop_front();
                got_r = reading_t'(m_tdata[$bits(reading_t)-1:0]);
                check_field("dac_drive", longint'(exp_r.dac_drive),
                            longint'(got_r.dac_drive));
                check_field("current_ma", longint'(exp_r.current_ma),
                            longint'(got_r.current_ma));
                check_field("voltage_mv", longint'(exp_r.voltage_mv),
                            longint'(got_r.voltage_mv));
                check_field("power_mw", longint'(exp_r.power_mw),
                            longint'(got_r.power_mw));
                check_field("setpoint_now", longint'(exp_r.setpoint_now),
                            longint'(got_r.setpoint_now));
                results_checked++;
            end
            out_hold = $urandom_range(0, idle_max);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        sel_mode = MODE_CUR;
        active_sp = '0;
        cgain = CGAIN_RST;
        vgain = VGAIN_RST;
        drive_level = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_corner_settings();
        test_random_regulation();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d samples regulated across all four mode codes, %0d register writes",
                 samples_sent, regs_written);
        $display("%0d readings checked, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
